@@ src/rti_pkg.sv @@
// Shared types and constants for the ray/triangle intersection block.
// Used by ray_triangle_intersection; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package rti_pkg;

    // Configuration register indexes.
    typedef enum logic [7:0] {
        REG_VERTEX_ZERO = 8'd0,
        REG_VERTEX_ONE  = 8'd1,
        REG_VERTEX_TWO  = 8'd2,
        REG_FACE_NORMAL = 8'd3
    } cfg_reg_t;

    localparam int CFG_INDEX_BITS = 8;

    // Distance format is signed Q16.16.
    localparam int T_BITS = 32;
    localparam int T_FRAC = 16;

    // Quotient bits produced by the divider (values up to 2^33 - 1).
    localparam int Q_BITS = T_BITS + 1;

endpackage

`default_nettype wire

@@ src/ray_triangle_intersection.sv @@
// Pipelined Moller-Trumbore ray/triangle test, one ray per clock unless stalled.
// Depends on rti_pkg for register indexes and distance format constants.
// The block accepts one ray every cycle while it is not stalled and returns one result per
// ray, in order: seven stages form the edges, cross products, dot products and the bound
// checks, a 33-stage restoring divider yields one quotient bit of the distance per stage,
// and three stages saturate the distance, test the window and form the hit point.
// Every stage holds its own valid bit and only stalls when the stages after it are full, so
// bubbles close up and rays enter while a result waits at the output, until all stages fill.
// Configuration writes are accepted in any cycle and should be made while no ray is in flight.
`timescale 1ns / 1ps
`default_nettype none

module ray_triangle_intersection #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Configuration write channel.
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [rti_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [3*COORD_BITS-1:0]             cfg_data,
    // Ray requests.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // Fields from bit 0 up: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max.
    input  wire logic [((6*COORD_BITS+64+7)/8)*8-1:0] s_tdata,
    // Results.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // Fields from bit 0 up: hit, t_value, point_x, point_y, point_z, hit_normal.
    output logic [((6*COORD_BITS+33+7)/8)*8-1:0]     m_tdata
);

    localparam int C    = COORD_BITS;
    localparam int FRAC = C / 2;
    localparam int E    = C + 1;          // edges and origin offset
    localparam int PM   = 2 * C + 2;      // cross product terms
    localparam int P    = 2 * C + 3;      // cross products
    localparam int QW   = E + P;          // dot product terms
    localparam int D    = QW + 2;         // dot products
    localparam int NW   = D + rti_pkg::T_FRAC;  // dividend
    localparam int DW   = D + rti_pkg::Q_BITS;  // widest shifted divisor
    localparam int TB   = rti_pkg::T_BITS;
    localparam int QB   = rti_pkg::Q_BITS;
    localparam int IN_W  = ((6 * C + 64 + 7) / 8) * 8;
    localparam int OUT_W = ((6 * C + 33 + 7) / 8) * 8;

    localparam longint BIAS_RAW = ((64'sd1 <<< (3 * FRAC)) + 64'sd5000) / 64'sd10000;
    localparam longint BIAS     = (BIAS_RAW == 0) ? 64'sd1 : BIAS_RAW;

    localparam int DIV0 = 7;              // first divider stage
    localparam int TSTG = DIV0 + QB;      // distance saturate and window test
    localparam int MSTG = TSTG + 1;       // distance times direction
    localparam int OSTG = MSTG + 1;       // output register
    localparam int NST  = OSTG + 1;

    typedef struct packed {
        logic [2:0][C-1:0] org;
        logic [2:0][C-1:0] dir;
        logic [TB-1:0]     tmin;
        logic [TB-1:0]     tmax;
    } ray_t;

    typedef struct packed {
        ray_t          ray;
        logic          pass;
        logic          cneg;
        logic          ovf;
        logic [NW-1:0] rem;
        logic [D-1:0]  dvsr;
        logic [QB-1:0] q;
    } div_t;

    // ---------------------------------------------------------------- configuration
    logic [3*C-1:0] vtx0_reg, vtx1_reg, vtx2_reg, norm_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vtx0_reg <= '0;
            vtx1_reg <= '0;
            vtx2_reg <= '0;
            norm_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rti_pkg::REG_VERTEX_ZERO: vtx0_reg <= cfg_data;
                rti_pkg::REG_VERTEX_ONE:  vtx1_reg <= cfg_data;
                rti_pkg::REG_VERTEX_TWO:  vtx2_reg <= cfg_data;
                rti_pkg::REG_FACE_NORMAL: norm_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- flow control
    logic [NST-1:0] vld_reg;
    logic [NST:0]   rdy;

    // A stage loads when it is empty or when the stage after it loads.
    always_comb begin
        rdy[NST] = m_tready;
        for (int k = NST - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[OSTG];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= (k == 0) ? s_tvalid : vld_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // ---------------------------------------------------------------- stage 0: edges
    ray_t            ray_in;
    ray_t            ray0_reg;
    logic signed [E-1:0] e0_0_reg[3], e1_0_reg[3], s_0_reg[3];

    assign ray_in.org  = s_tdata[3*C-1:0];
    assign ray_in.dir  = s_tdata[6*C-1:3*C];
    assign ray_in.tmin = s_tdata[6*C+TB-1:6*C];
    assign ray_in.tmax = s_tdata[6*C+2*TB-1:6*C+TB];

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            ray0_reg <= ray_in;
            for (int k = 0; k < 3; k++) begin
                e0_0_reg[k] <= E'($signed(vtx1_reg[k*C +: C])) - E'($signed(vtx0_reg[k*C +: C]));
                e1_0_reg[k] <= E'($signed(vtx2_reg[k*C +: C])) - E'($signed(vtx0_reg[k*C +: C]));
                s_0_reg[k]  <= E'($signed(ray_in.org[k])) - E'($signed(vtx0_reg[k*C +: C]));
            end
        end
    end

    // ---------------------------------------------------------------- stage 1: cross terms
    ray_t                 ray1_reg;
    logic signed [E-1:0]  e0_1_reg[3], e1_1_reg[3], s_1_reg[3];
    logic signed [PM-1:0] pvp_reg[6], qvp_reg[6];
    logic signed [C-1:0]  d0[3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d0[k] = $signed(ray0_reg.dir[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            ray1_reg   <= ray0_reg;
            e0_1_reg   <= e0_0_reg;
            e1_1_reg   <= e1_0_reg;
            s_1_reg    <= s_0_reg;
            pvp_reg[0] <= PM'(d0[1]) * PM'(e1_0_reg[2]);
            pvp_reg[1] <= PM'(d0[2]) * PM'(e1_0_reg[1]);
            pvp_reg[2] <= PM'(d0[2]) * PM'(e1_0_reg[0]);
            pvp_reg[3] <= PM'(d0[0]) * PM'(e1_0_reg[2]);
            pvp_reg[4] <= PM'(d0[0]) * PM'(e1_0_reg[1]);
            pvp_reg[5] <= PM'(d0[1]) * PM'(e1_0_reg[0]);
            qvp_reg[0] <= PM'(s_0_reg[1]) * PM'(e0_0_reg[2]);
            qvp_reg[1] <= PM'(s_0_reg[2]) * PM'(e0_0_reg[1]);
            qvp_reg[2] <= PM'(s_0_reg[2]) * PM'(e0_0_reg[0]);
            qvp_reg[3] <= PM'(s_0_reg[0]) * PM'(e0_0_reg[2]);
            qvp_reg[4] <= PM'(s_0_reg[0]) * PM'(e0_0_reg[1]);
            qvp_reg[5] <= PM'(s_0_reg[1]) * PM'(e0_0_reg[0]);
        end
    end

    // ---------------------------------------------------------------- stage 2: cross products
    ray_t                ray2_reg;
    logic signed [E-1:0] e0_2_reg[3], e1_2_reg[3], s_2_reg[3];
    logic signed [P-1:0] pv_reg[3], qv_reg[3];

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            ray2_reg <= ray1_reg;
            e0_2_reg <= e0_1_reg;
            e1_2_reg <= e1_1_reg;
            s_2_reg  <= s_1_reg;
            for (int k = 0; k < 3; k++) begin
                pv_reg[k] <= P'(pvp_reg[2*k]) - P'(pvp_reg[2*k+1]);
                qv_reg[k] <= P'(qvp_reg[2*k]) - P'(qvp_reg[2*k+1]);
            end
        end
    end

    // ---------------------------------------------------------------- stage 3: dot terms
    ray_t                 ray3_reg;
    logic signed [QW-1:0] detp_reg[3], ap_reg[3], bp_reg[3], cp_reg[3];

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            ray3_reg <= ray2_reg;
            for (int k = 0; k < 3; k++) begin
                detp_reg[k] <= QW'(e0_2_reg[k]) * QW'(pv_reg[k]);
                ap_reg[k]   <= QW'(s_2_reg[k]) * QW'(pv_reg[k]);
                bp_reg[k]   <= QW'($signed(ray2_reg.dir[k])) * QW'(qv_reg[k]);
                cp_reg[k]   <= QW'(e1_2_reg[k]) * QW'(qv_reg[k]);
            end
        end
    end

    // ---------------------------------------------------------------- stage 4: dot sums
    ray_t                ray4_reg;
    logic signed [D-1:0] det_reg, a_reg, b_reg, c_reg;

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            ray4_reg <= ray3_reg;
            det_reg  <= D'(detp_reg[0]) + D'(detp_reg[1]) + D'(detp_reg[2]);
            a_reg    <= D'(ap_reg[0]) + D'(ap_reg[1]) + D'(ap_reg[2]);
            b_reg    <= D'(bp_reg[0]) + D'(bp_reg[1]) + D'(bp_reg[2]);
            c_reg    <= D'(cp_reg[0]) + D'(cp_reg[1]) + D'(cp_reg[2]);
        end
    end

    // ---------------------------------------------------------------- stage 5: sign fold
    ray_t                  ray5_reg;
    logic [D-1:0]          adet_reg, cmag_reg;
    logic signed [D:0]     an_reg, bn_reg;
    logic                  cneg5_reg;
    logic                  det_neg;
    logic signed [D:0]     a_ext, b_ext;

    assign det_neg = det_reg[D-1];
    assign a_ext   = $signed({a_reg[D-1], a_reg});
    assign b_ext   = $signed({b_reg[D-1], b_reg});

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            ray5_reg  <= ray4_reg;
            adet_reg  <= det_neg ? D'(-det_reg) : D'(det_reg);
            an_reg    <= det_neg ? -a_ext : a_ext;
            bn_reg    <= det_neg ? -b_ext : b_ext;
            cmag_reg  <= c_reg[D-1] ? D'(-c_reg) : D'(c_reg);
            cneg5_reg <= (c_reg[D-1] != det_neg) && (c_reg != '0);
        end
    end

    // ---------------------------------------------------------------- stage 6: bound checks
    div_t               chk_reg;
    logic               too_small, a_bad, b_bad;
    logic signed [D+1:0] ab_sum;

    always_comb begin
        too_small = adet_reg < D'(BIAS);
        a_bad     = an_reg[D] || (an_reg > $signed({1'b0, adet_reg}));
        ab_sum    = $signed({an_reg[D], an_reg}) + $signed({bn_reg[D], bn_reg});
        b_bad     = bn_reg[D] || (ab_sum > $signed({2'b00, adet_reg}));
    end

    always_ff @(posedge aclk) begin
        if (rdy[6]) begin
            chk_reg.ray  <= ray5_reg;
            chk_reg.pass <= !(too_small || a_bad || b_bad);
            chk_reg.cneg <= cneg5_reg;
            // A quotient of 2^33 or more saturates whatever its low bits are.
            chk_reg.ovf  <= {{(QB-rti_pkg::T_FRAC){1'b0}}, cmag_reg, {rti_pkg::T_FRAC{1'b0}}}
                            >= {adet_reg, {QB{1'b0}}};
            chk_reg.rem  <= {cmag_reg, {rti_pkg::T_FRAC{1'b0}}};
            chk_reg.dvsr <= adet_reg;
            chk_reg.q    <= '0;
        end
    end

    // ---------------------------------------------------------------- divider
    div_t div_reg[QB];

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int BIT = QB - 1 - j;
        div_t          src;
        div_t          res;
        logic [DW-1:0] dsh;
        logic [DW-1:0] remx;

        if (j == 0) begin : g_first
            assign src = chk_reg;
        end else begin : g_next
            assign src = div_reg[j-1];
        end

        always_comb begin
            dsh  = DW'(src.dvsr) << BIT;
            remx = DW'(src.rem);
            res  = src;
            if (remx >= dsh) begin
                res.rem    = NW'(remx - dsh);
                res.q[BIT] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[DIV0+j]) begin
                div_reg[j] <= res;
            end
        end
    end

    // ---------------------------------------------------------------- distance and window
    div_t                 dv;
    logic signed [TB-1:0] t_sat;
    ray_t                 rayt_reg;
    logic signed [TB-1:0] t_reg;
    logic                 hitt_reg;

    assign dv = div_reg[QB-1];

    always_comb begin
        if (dv.cneg) begin
            if (dv.ovf || dv.q > (QB'(1) << (TB - 1))) begin
                t_sat = {1'b1, {(TB-1){1'b0}}};
            end else begin
                t_sat = -$signed(dv.q[TB-1:0]);
            end
        end else begin
            if (dv.ovf || dv.q[QB-1] || dv.q[TB-1]) begin
                t_sat = {1'b0, {(TB-1){1'b1}}};
            end else begin
                t_sat = $signed(dv.q[TB-1:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[TSTG]) begin
            rayt_reg <= dv.ray;
            t_reg    <= t_sat;
            hitt_reg <= dv.pass && ($signed(dv.ray.tmin) <= t_sat)
                        && (t_sat <= $signed(dv.ray.tmax));
        end
    end

    // ---------------------------------------------------------------- distance times direction
    logic signed [TB+C-1:0] tprod_reg[3];
    logic [2:0][C-1:0]      orgm_reg;
    logic signed [TB-1:0]   tm_reg;
    logic                   hitm_reg;

    always_ff @(posedge aclk) begin
        if (rdy[MSTG]) begin
            orgm_reg <= rayt_reg.org;
            tm_reg   <= t_reg;
            hitm_reg <= hitt_reg;
            for (int k = 0; k < 3; k++) begin
                tprod_reg[k] <= (TB+C)'(t_reg) * (TB+C)'($signed(rayt_reg.dir[k]));
            end
        end
    end

    // ---------------------------------------------------------------- output
    logic signed [C+16:0] psum[3];
    logic [C-1:0]         psat[3];
    logic                 hit_reg;
    logic [TB-1:0]        tval_reg;
    logic [2:0][C-1:0]    point_reg;
    logic [3*C-1:0]       hnorm_reg;

    // The arithmetic shift floors the scaled product onto the coordinate grid.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            psum[k] = (C+17)'($signed(orgm_reg[k]))
                      + (C+17)'(tprod_reg[k] >>> rti_pkg::T_FRAC);
            if (psum[k] > (C+17)'(signed'({1'b0, {(C-1){1'b1}}}))) begin
                psat[k] = {1'b0, {(C-1){1'b1}}};
            end else if (psum[k] < -(C+17)'(signed'({1'b0, 1'b1, {(C-1){1'b0}}}))) begin
                psat[k] = {1'b1, {(C-1){1'b0}}};
            end else begin
                psat[k] = psum[k][C-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[OSTG]) begin
            hit_reg   <= hitm_reg;
            tval_reg  <= hitm_reg ? tm_reg : '0;
            hnorm_reg <= hitm_reg ? norm_reg : '0;
            for (int k = 0; k < 3; k++) begin
                point_reg[k] <= hitm_reg ? psat[k] : '0;
            end
        end
    end

    assign m_tdata = OUT_W'({hnorm_reg, point_reg, tval_reg, hit_reg});

    // ---------------------------------------------------------------- assertions
    // A miss carries all-zero fields.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !hit_reg) |-> (tval_reg == '0 && hnorm_reg == '0 && point_reg == '0))
        else $error("miss result with nonzero fields");

    // An empty output stage means every stage before it can load.
    a_drain_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[OSTG] |-> s_tready)
        else $error("input stalled while output stage empty");

    // A ray that passed the checks had a determinant at least as large as the bias.
    a_bias: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[6] && chk_reg.pass) |-> (chk_reg.dvsr >= D'(BIAS)))
        else $error("near-parallel ray passed the determinant check");

    // A hit leaving the window stage lies inside its window.
    a_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[TSTG] && hitt_reg) |->
            ($signed(rayt_reg.tmin) <= t_reg && t_reg <= $signed(rayt_reg.tmax)))
        else $error("hit outside distance window");

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("output changed under stall");

endmodule

`default_nettype wire
